/* src/lspb_pkg.sv */
package lspb_pkg;

  // Field and register widths fixed by the interface.
  localparam int unsigned OPCODE_W     = 3;
  localparam int unsigned INDEX_W      = 10;
  localparam int unsigned CHAN_W       = 8;
  localparam int unsigned PIXEL_W      = 3 * CHAN_W;
  localparam int unsigned STRIP_LEN_W  = 9;
  localparam int unsigned ORDER_W      = 2;
  localparam int unsigned CFG_DATA_W   = 9;
  localparam int unsigned CFG_INDEX_W  = 1;
  localparam int unsigned BYTE_SEL_W   = 2;

  localparam logic [STRIP_LEN_W-1:0] STRIP_LEN_RESET = 9'd256;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_STRIP_LENGTH = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COLOR_ORDER  = 1'd1;

  // Wire byte orders. The unused code falls back to RGB.
  localparam logic [ORDER_W-1:0] ORDER_RGB = 2'd0;
  localparam logic [ORDER_W-1:0] ORDER_BGR = 2'd1;
  localparam logic [ORDER_W-1:0] ORDER_GRB = 2'd2;

  // Operation codes.
  localparam logic [OPCODE_W-1:0] OP_SET        = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_GET        = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_FILL       = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_NEXT_BYTE  = 3'd5;

  // Byte positions inside one stored pixel.
  localparam logic [BYTE_SEL_W-1:0] BYTE_FIRST = 2'd0;
  localparam logic [BYTE_SEL_W-1:0] BYTE_MID   = 2'd1;
  localparam logic [BYTE_SEL_W-1:0] BYTE_LAST  = 2'd2;

  // Jobs handed to the store sequencer.
  typedef enum logic [2:0] {
    JOB_WRITE,
    JOB_READ,
    JOB_PUSH_FRONT,
    JOB_PUSH_BACK,
    JOB_FILL
  } lspb_job_e;

  typedef struct packed {
    logic      go;
    lspb_job_e job;
  } lspb_cmd_t;

  typedef struct packed {
    logic idle;
    logic done;
  } lspb_stat_t;

  typedef struct packed {
    logic [CHAN_W-1:0] r;
    logic [CHAN_W-1:0] g;
    logic [CHAN_W-1:0] b;
  } lspb_rgb_t;

  // Pack a color into wire order; the first wire byte sits in the top bits.
  function automatic logic [PIXEL_W-1:0] encode(input logic [ORDER_W-1:0] order,
                                                input logic [CHAN_W-1:0] r,
                                                input logic [CHAN_W-1:0] g,
                                                input logic [CHAN_W-1:0] b);
    logic [PIXEL_W-1:0] p;
    unique case (order)
      ORDER_BGR: p = {b, g, r};
      ORDER_GRB: p = {g, r, b};
      default:   p = {r, g, b};
    endcase
    return p;
  endfunction

  // Unpack a stored wire-order pixel with the current order.
  function automatic lspb_rgb_t decode(input logic [ORDER_W-1:0] order,
                                       input logic [PIXEL_W-1:0] p);
    lspb_rgb_t c;
    unique case (order)
      ORDER_BGR: begin
        c.b = p[23:16]; c.g = p[15:8]; c.r = p[7:0];
      end
      ORDER_GRB: begin
        c.g = p[23:16]; c.r = p[15:8]; c.b = p[7:0];
      end
      default: begin
        c.r = p[23:16]; c.g = p[15:8]; c.b = p[7:0];
      end
    endcase
    return c;
  endfunction

endpackage

/* src/lspb_store.sv */
module lspb_store #(
  parameter int unsigned Depth = 256
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [lspb_pkg::PIXEL_W-1:0]          wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [lspb_pkg::PIXEL_W-1:0]          rdata_o
);

  logic [lspb_pkg::PIXEL_W-1:0] mem [Depth];
  logic [lspb_pkg::PIXEL_W-1:0] rdata_q;

  // Single write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/lspb_seq.sv */
module lspb_seq #(
  parameter int unsigned MaxPixels = 256
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  lspb_pkg::lspb_cmd_t                   cmd_i,
  input  logic [$clog2(MaxPixels+1)-1:0]        len_i,
  input  logic [((MaxPixels > 1) ? $clog2(MaxPixels) : 1)-1:0] addr_i,
  input  logic [lspb_pkg::PIXEL_W-1:0]          pix_i,
  input  logic [lspb_pkg::PIXEL_W-1:0]          rdata_i,
  output lspb_pkg::lspb_stat_t                  stat_o,
  output logic                                  we_o,
  output logic [((MaxPixels > 1) ? $clog2(MaxPixels) : 1)-1:0] waddr_o,
  output logic [lspb_pkg::PIXEL_W-1:0]          wdata_o,
  output logic [((MaxPixels > 1) ? $clog2(MaxPixels) : 1)-1:0] raddr_o
);

  localparam int unsigned LenW  = $clog2(MaxPixels + 1);
  localparam int unsigned AddrW = (MaxPixels > 1) ? $clog2(MaxPixels) : 1;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_READ  = 2'd2;
  localparam logic [1:0] S_WALK  = 2'd3;

  logic [1:0]                   state_q, state_d;
  logic [LenW-1:0]              k_q, k_d;
  lspb_pkg::lspb_job_e          job_q, job_d;
  logic [lspb_pkg::PIXEL_W-1:0] pix_q, pix_d;
  logic                         walk_last;

  // Last step of a walk: fill ends on the last pixel, a push one step later
  // when the new color goes in.
  always_comb begin
    if (job_q == lspb_pkg::JOB_FILL) begin
      walk_last = (k_q == len_i - 1'b1);
    end else begin
      walk_last = (k_q == len_i);
    end
  end

  // Sequencer and the shared address unit.
  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    job_d   = job_q;
    pix_d   = pix_q;
    we_o    = 1'b0;
    waddr_o = addr_i;
    wdata_o = pix_i;
    raddr_o = addr_i;
    stat_o  = '{idle: 1'b0, done: 1'b0};

    unique case (state_q)
      S_CLEAR: begin
        we_o    = 1'b1;
        waddr_o = AddrW'(k_q);
        wdata_o = '0;
        k_d     = k_q + 1'b1;
        if (k_q == LenW'(MaxPixels - 1)) begin
          k_d     = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        stat_o.idle = 1'b1;
        if (cmd_i.go) begin
          job_d = cmd_i.job;
          pix_d = pix_i;
          k_d   = '0;
          unique case (cmd_i.job)
            lspb_pkg::JOB_WRITE: we_o = 1'b1;
            lspb_pkg::JOB_READ:  state_d = S_READ;
            default:             state_d = S_WALK;
          endcase
        end
      end
      S_READ: begin
        // Read data for the address issued at the start is on rdata_i now.
        stat_o.done = 1'b1;
        state_d     = S_IDLE;
      end
      S_WALK: begin
        k_d = k_q + 1'b1;
        unique case (job_q)
          lspb_pkg::JOB_PUSH_FRONT: begin
            raddr_o = AddrW'(len_i - LenW'(2) - k_q);
            waddr_o = AddrW'(len_i - k_q);
            we_o    = (k_q != '0);
          end
          lspb_pkg::JOB_PUSH_BACK: begin
            raddr_o = AddrW'(k_q + 1'b1);
            waddr_o = AddrW'(k_q - 1'b1);
            we_o    = (k_q != '0);
          end
          default: begin
            raddr_o = AddrW'(k_q);
            waddr_o = AddrW'(k_q);
            we_o    = 1'b1;
          end
        endcase
        // The pixel read one step ago moves; the end slot takes the new color.
        if (job_q == lspb_pkg::JOB_FILL || k_q == len_i) begin
          wdata_o = pix_q;
        end else begin
          wdata_o = rdata_i;
        end
        if (walk_last) begin
          stat_o.done = 1'b1;
          k_d         = '0;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      k_q     <= '0;
      job_q   <= lspb_pkg::JOB_WRITE;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      job_q   <= job_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q <= pix_d;
  end

endmodule

/* src/led_strip_pixel_buffer_core.sv */
// Channel  | Direction | Handshake            | Payload
// ---------+-----------+----------------------+---------------------------------------------
// in       | input     | in_valid_i/in_ready_o | opcode_i, pixel_index_i, red_i, green_i, blue_i
// out      | output    | out_valid_o/out_ready_i | red_out_o, green_out_o, blue_out_o,
//          |           |                      | wire_byte_o, frame_end_o
// cfg      | input     | cfg_we_i (no wait)   | cfg_index_i, cfg_data_i
//
// Set, unused codes and out-of-range or empty-strip cases are answered without a read or a walk.
// Get and next-byte wait for a read: the pixel store has one registered read port.
// Push and fill walk the strip one pixel per cycle through the
// single store write port (len = min(strip_length, MAX_PIXELS)).
// After reset a clearing pass zeroes all MAX_PIXELS store entries; no input
// transfer is taken until it ends. A waiting result holds off only the next input.
module led_strip_pixel_buffer_core #(
  parameter int unsigned MAX_PIXELS = 256
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [lspb_pkg::CFG_INDEX_W-1:0]     cfg_index_i,
  input  logic [lspb_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [lspb_pkg::OPCODE_W-1:0]        opcode_i,
  input  logic [lspb_pkg::INDEX_W-1:0]         pixel_index_i,
  input  logic [lspb_pkg::CHAN_W-1:0]          red_i,
  input  logic [lspb_pkg::CHAN_W-1:0]          green_i,
  input  logic [lspb_pkg::CHAN_W-1:0]          blue_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [lspb_pkg::CHAN_W-1:0]          red_out_o,
  output logic [lspb_pkg::CHAN_W-1:0]          green_out_o,
  output logic [lspb_pkg::CHAN_W-1:0]          blue_out_o,
  output logic [lspb_pkg::CHAN_W-1:0]          wire_byte_o,
  output logic                                 frame_end_o
);

  localparam int unsigned LenW  = $clog2(MAX_PIXELS + 1);
  localparam int unsigned AddrW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int unsigned CmpW  = (LenW > lspb_pkg::INDEX_W) ? LenW : lspb_pkg::INDEX_W;

  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_GET  = 2'd1;
  localparam logic [1:0] PEND_BYTE = 2'd2;

  // Configuration registers.
  logic [lspb_pkg::STRIP_LEN_W-1:0] strip_length_q;
  logic [lspb_pkg::ORDER_W-1:0]     color_order_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strip_length_q <= lspb_pkg::STRIP_LEN_RESET;
      color_order_q  <= lspb_pkg::ORDER_RGB;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        lspb_pkg::REG_STRIP_LENGTH: strip_length_q <= cfg_data_i[lspb_pkg::STRIP_LEN_W-1:0];
        lspb_pkg::REG_COLOR_ORDER:  color_order_q  <= cfg_data_i[lspb_pkg::ORDER_W-1:0];
        default: ;
      endcase
    end
  end

  // Active length, capped at the store depth.
  logic [LenW-1:0] len;
  assign len = (CmpW'(strip_length_q) < CmpW'(MAX_PIXELS)) ? LenW'(strip_length_q)
                                                            : LenW'(MAX_PIXELS);

  // Store, sequencer and their connections.
  lspb_pkg::lspb_cmd_t          cmd;
  lspb_pkg::lspb_stat_t         stat;
  logic [AddrW-1:0]             cmd_addr;
  logic [lspb_pkg::PIXEL_W-1:0] enc_pix;
  logic                         mem_we;
  logic [AddrW-1:0]             mem_waddr;
  logic [AddrW-1:0]             mem_raddr;
  logic [lspb_pkg::PIXEL_W-1:0] mem_wdata;
  logic [lspb_pkg::PIXEL_W-1:0] mem_rdata;

  assign enc_pix = lspb_pkg::encode(color_order_q, red_i, green_i, blue_i);

  lspb_store #(
    .Depth (MAX_PIXELS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  lspb_seq #(
    .MaxPixels (MAX_PIXELS)
  ) u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .len_i   (len),
    .addr_i  (cmd_addr),
    .pix_i   (enc_pix),
    .rdata_i (mem_rdata),
    .stat_o  (stat),
    .we_o    (mem_we),
    .waddr_o (mem_waddr),
    .wdata_o (mem_wdata),
    .raddr_o (mem_raddr)
  );

  // Input transfer: only when the sequencer is free and the result slot is free
  // or emptying in this cycle.
  logic out_valid_q, out_valid_d;
  logic accept;

  assign in_ready_o = stat.idle && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  // Wire cursor kept as pixel and byte position.
  logic [AddrW-1:0]               cur_pix_q, cur_pix_d;
  logic [lspb_pkg::BYTE_SEL_W-1:0] cur_byte_q, cur_byte_d;
  logic [AddrW-1:0]               eff_pix;
  logic [lspb_pkg::BYTE_SEL_W-1:0] eff_byte;
  logic                           cur_restart;
  logic                           frame_last;

  assign cur_restart = (LenW'(cur_pix_q) >= len);
  assign eff_pix     = cur_restart ? '0 : cur_pix_q;
  assign eff_byte    = cur_restart ? lspb_pkg::BYTE_FIRST : cur_byte_q;
  assign frame_last  = (LenW'(eff_pix) == len - 1'b1) && (eff_byte == lspb_pkg::BYTE_LAST);

  // Operation decode.
  logic                            idx_ok;
  logic                            len_nz;
  logic                            imm;
  logic                            imm_fe;
  logic [1:0]                      pend_q, pend_d;
  logic [lspb_pkg::BYTE_SEL_W-1:0] pend_byte_q, pend_byte_d;
  logic                            pend_fe_q, pend_fe_d;

  assign idx_ok = (CmpW'(pixel_index_i) < CmpW'(len));
  assign len_nz = (len != '0);

  always_comb begin
    cmd         = '{go: 1'b0, job: lspb_pkg::JOB_WRITE};
    cmd_addr    = pixel_index_i[AddrW-1:0];
    imm         = 1'b1;
    imm_fe      = 1'b0;
    pend_d      = pend_q;
    pend_byte_d = pend_byte_q;
    pend_fe_d   = pend_fe_q;
    cur_pix_d   = cur_pix_q;
    cur_byte_d  = cur_byte_q;
    if (accept) begin
      pend_d = PEND_NONE;
      unique case (opcode_i)
        lspb_pkg::OP_SET: begin
          cmd.go = idx_ok;
        end
        lspb_pkg::OP_GET: begin
          if (idx_ok) begin
            cmd    = '{go: 1'b1, job: lspb_pkg::JOB_READ};
            imm    = 1'b0;
            pend_d = PEND_GET;
          end
        end
        lspb_pkg::OP_PUSH_FRONT: begin
          cmd = '{go: len_nz, job: lspb_pkg::JOB_PUSH_FRONT};
          imm = !len_nz;
        end
        lspb_pkg::OP_PUSH_BACK: begin
          cmd = '{go: len_nz, job: lspb_pkg::JOB_PUSH_BACK};
          imm = !len_nz;
        end
        lspb_pkg::OP_FILL: begin
          cmd = '{go: len_nz, job: lspb_pkg::JOB_FILL};
          imm = !len_nz;
        end
        lspb_pkg::OP_NEXT_BYTE: begin
          if (!len_nz) begin
            imm_fe     = 1'b1;
            cur_pix_d  = '0;
            cur_byte_d = lspb_pkg::BYTE_FIRST;
          end else begin
            cmd         = '{go: 1'b1, job: lspb_pkg::JOB_READ};
            cmd_addr    = eff_pix;
            imm         = 1'b0;
            pend_d      = PEND_BYTE;
            pend_byte_d = eff_byte;
            pend_fe_d   = frame_last;
            // Advance the cursor, wrapping after the frame's last byte.
            if (frame_last) begin
              cur_pix_d  = '0;
              cur_byte_d = lspb_pkg::BYTE_FIRST;
            end else if (eff_byte == lspb_pkg::BYTE_LAST) begin
              cur_pix_d  = AddrW'(eff_pix + 1'b1);
              cur_byte_d = lspb_pkg::BYTE_FIRST;
            end else begin
              cur_pix_d  = eff_pix;
              cur_byte_d = eff_byte + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_pix_q  <= '0;
      cur_byte_q <= lspb_pkg::BYTE_FIRST;
      pend_q     <= PEND_NONE;
    end else begin
      cur_pix_q  <= cur_pix_d;
      cur_byte_q <= cur_byte_d;
      pend_q     <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_byte_q <= pend_byte_d;
    pend_fe_q   <= pend_fe_d;
  end

  // Result register.
  lspb_pkg::lspb_rgb_t           rd_rgb;
  logic [lspb_pkg::CHAN_W-1:0]   rd_byte;
  lspb_pkg::lspb_rgb_t           res_rgb_q, res_rgb_d;
  logic [lspb_pkg::CHAN_W-1:0]   res_byte_q, res_byte_d;
  logic                          res_fe_q, res_fe_d;

  assign rd_rgb = lspb_pkg::decode(color_order_q, mem_rdata);

  always_comb begin
    case (pend_byte_q)
      lspb_pkg::BYTE_FIRST: rd_byte = mem_rdata[23:16];
      lspb_pkg::BYTE_MID:   rd_byte = mem_rdata[15:8];
      default:              rd_byte = mem_rdata[7:0];
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    res_rgb_d   = res_rgb_q;
    res_byte_d  = res_byte_q;
    res_fe_d    = res_fe_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (accept && imm) begin
      out_valid_d = 1'b1;
      res_rgb_d   = '0;
      res_byte_d  = '0;
      res_fe_d    = imm_fe;
    end else if (stat.done) begin
      out_valid_d = 1'b1;
      res_rgb_d   = '0;
      res_byte_d  = '0;
      res_fe_d    = 1'b0;
      case (pend_q)
        PEND_GET: begin
          res_rgb_d = rd_rgb;
        end
        PEND_BYTE: begin
          res_byte_d = rd_byte;
          res_fe_d   = pend_fe_q;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_rgb_q  <= res_rgb_d;
    res_byte_q <= res_byte_d;
    res_fe_q   <= res_fe_d;
  end

  assign out_valid_o = out_valid_q;
  assign red_out_o   = res_rgb_q.r;
  assign green_out_o = res_rgb_q.g;
  assign blue_out_o  = res_rgb_q.b;
  assign wire_byte_o = res_byte_q;
  assign frame_end_o = res_fe_q;

  // A finished job must always find the result slot empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.done |-> !out_valid_q)
    else $error("sequencer finished while a result was still waiting");

  // Input is never taken while an untaken result would be overwritten.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (!out_valid_q || out_ready_i))
    else $error("input ready while the result slot is blocked");

  // Only next-byte results raise frame_end, and those carry no color.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_end_o) |->
      (red_out_o == '0 && green_out_o == '0 && blue_out_o == '0))
    else $error("frame end flagged on a result with color");

  // A walk or read job is only started from an accepted item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.go |-> accept)
    else $error("store job started without an input transfer");

endmodule

/* tb/pixel_buffer_tracker.sv */
module pixel_buffer_tracker #(
  parameter int unsigned MAX_PIXELS = 256
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [lspb_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [lspb_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             in_valid_i,
  input  logic                             in_ready_i,
  input  logic [lspb_pkg::OPCODE_W-1:0]    opcode_i,
  input  logic [lspb_pkg::INDEX_W-1:0]     pixel_index_i,
  input  logic [lspb_pkg::CHAN_W-1:0]      red_i,
  input  logic [lspb_pkg::CHAN_W-1:0]      green_i,
  input  logic [lspb_pkg::CHAN_W-1:0]      blue_i,
  input  logic                             out_valid_i,
  input  logic                             out_ready_i,
  input  logic [lspb_pkg::CHAN_W-1:0]      red_out_i,
  input  logic [lspb_pkg::CHAN_W-1:0]      green_out_i,
  input  logic [lspb_pkg::CHAN_W-1:0]      blue_out_i,
  input  logic [lspb_pkg::CHAN_W-1:0]      wire_byte_i,
  input  logic                             frame_end_i,
  output int unsigned                      fail_count_o,
  output int unsigned                      pending_o,
  output int unsigned                      replies_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [lspb_pkg::CHAN_W-1:0] red;
    logic [lspb_pkg::CHAN_W-1:0] green;
    logic [lspb_pkg::CHAN_W-1:0] blue;
    logic [lspb_pkg::CHAN_W-1:0] wire_byte;
    logic                        frame_end;
  } strip_reply_t;

  // Shadow copy of the pixel store, the frame cursor and both registers.
  logic [lspb_pkg::PIXEL_W-1:0]     strip_mem [MAX_PIXELS];
  int unsigned                      frame_pos;
  logic [lspb_pkg::STRIP_LEN_W-1:0] len_reg;
  logic [lspb_pkg::ORDER_W-1:0]     order_reg;

  strip_reply_t expected_replies [$];
  int unsigned  fail_count;
  int unsigned  reply_count;

  // Pack a color so that the first byte on the wire sits in the top bits.
  function automatic logic [lspb_pkg::PIXEL_W-1:0] to_wire(
      input logic [lspb_pkg::CHAN_W-1:0] r,
      input logic [lspb_pkg::CHAN_W-1:0] g,
      input logic [lspb_pkg::CHAN_W-1:0] b);
    case (order_reg)
      lspb_pkg::ORDER_BGR: return {b, g, r};
      lspb_pkg::ORDER_GRB: return {g, r, b};
      default:             return {r, g, b};
    endcase
  endfunction

  // Read a stored pixel back as a color with the order in force now.
  function automatic strip_reply_t from_wire(input logic [lspb_pkg::PIXEL_W-1:0] px);
    strip_reply_t c;
    c = '0;
    case (order_reg)
      lspb_pkg::ORDER_BGR: begin
        c.blue = px[23:16]; c.green = px[15:8]; c.red = px[7:0];
      end
      lspb_pkg::ORDER_GRB: begin
        c.green = px[23:16]; c.red = px[15:8]; c.blue = px[7:0];
      end
      default: begin
        c.red = px[23:16]; c.green = px[15:8]; c.blue = px[7:0];
      end
    endcase
    return c;
  endfunction

  // Apply one operation to the shadow store and return the reply it causes.
  function automatic strip_reply_t apply_pixel_op(
      input logic [lspb_pkg::OPCODE_W-1:0] op,
      input logic [lspb_pkg::INDEX_W-1:0]  idx,
      input logic [lspb_pkg::CHAN_W-1:0]   r,
      input logic [lspb_pkg::CHAN_W-1:0]   g,
      input logic [lspb_pkg::CHAN_W-1:0]   b);
    strip_reply_t                 reply;
    int                           n;
    int                           k;
    int unsigned                  total;
    logic [lspb_pkg::PIXEL_W-1:0] px;
    reply = '0;
    n = (len_reg > MAX_PIXELS) ? MAX_PIXELS : int'(len_reg);
    case (op)
      lspb_pkg::OP_SET: begin
        if (idx < n) strip_mem[idx] = to_wire(r, g, b);
      end
      lspb_pkg::OP_GET: begin
        if (idx < n) reply = from_wire(strip_mem[idx]);
      end
      lspb_pkg::OP_PUSH_FRONT: begin
        if (n > 0) begin
          for (k = n - 1; k > 0; k--) strip_mem[k] = strip_mem[k-1];
          strip_mem[0] = to_wire(r, g, b);
        end
      end
      lspb_pkg::OP_PUSH_BACK: begin
        if (n > 0) begin
          for (k = 0; k + 1 < n; k++) strip_mem[k] = strip_mem[k+1];
          strip_mem[n-1] = to_wire(r, g, b);
        end
      end
      lspb_pkg::OP_FILL: begin
        for (k = 0; k < n; k++) strip_mem[k] = to_wire(r, g, b);
      end
      lspb_pkg::OP_NEXT_BYTE: begin
        if (n == 0) begin
          // An empty strip ends its frame at once and keeps the cursor home.
          frame_pos = 0;
          reply.frame_end = 1'b1;
        end else begin
          total = 3 * n;
          // A cursor left past a shrunken frame starts over.
          if (frame_pos >= total) frame_pos = 0;
          px = strip_mem[frame_pos / 3];
          case (lspb_pkg::BYTE_SEL_W'(frame_pos % 3))
            lspb_pkg::BYTE_FIRST: reply.wire_byte = px[23:16];
            lspb_pkg::BYTE_MID:   reply.wire_byte = px[15:8];
            default:              reply.wire_byte = px[7:0];
          endcase
          if (frame_pos == total - 1) begin
            reply.frame_end = 1'b1;
            frame_pos = 0;
          end else begin
            frame_pos++;
          end
        end
      end
      default: ;
    endcase
    return reply;
  endfunction

  // Results are matched first, so a transfer in the same cycle never pairs with its own input.
  // Counters go out through nonblocking assignments so the stimulus side reads them without a race.
  always @(posedge clk_i or negedge rst_ni) begin
    strip_reply_t got;
    strip_reply_t want;
    if (!rst_ni) begin
      foreach (strip_mem[k]) strip_mem[k] = '0;
      frame_pos = 0;
      len_reg = lspb_pkg::STRIP_LEN_RESET;
      order_reg = lspb_pkg::ORDER_RGB;
      expected_replies.delete();
      fail_count = 0;
      reply_count = 0;
      fail_count_o <= 0;
      pending_o <= 0;
      replies_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got.red = red_out_i;
        got.green = green_out_i;
        got.blue = blue_out_i;
        got.wire_byte = wire_byte_i;
        got.frame_end = frame_end_i;
        reply_count++;
        if (expected_replies.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: result with nothing outstanding: rgb %h %h %h byte %h end %b",
                     $time, got.red, got.green, got.blue, got.wire_byte, got.frame_end);
          fail_count++;
        end else begin
          want = expected_replies.pop_front();
          if (got != want) begin
            if (fail_count < 10)
              $display({"%0t: result %0d expected rgb %h %h %h byte %h end %b,",
                        " got rgb %h %h %h byte %h end %b"}, $time, reply_count,
                       want.red, want.green, want.blue, want.wire_byte, want.frame_end,
                       got.red, got.green, got.blue, got.wire_byte, got.frame_end);
            fail_count++;
          end
        end
      end
      if (in_valid_i && in_ready_i)
        expected_replies.push_back(apply_pixel_op(opcode_i, pixel_index_i,
                                                  red_i, green_i, blue_i));
      if (cfg_we_i) begin
        case (cfg_index_i)
          lspb_pkg::REG_STRIP_LENGTH: len_reg = cfg_data_i[lspb_pkg::STRIP_LEN_W-1:0];
          lspb_pkg::REG_COLOR_ORDER:  order_reg = cfg_data_i[lspb_pkg::ORDER_W-1:0];
          default: ;
        endcase
      end
      fail_count_o <= fail_count;
      pending_o <= expected_replies.size();
      replies_o <= reply_count;
    end
  end

endmodule

/* tb/led_strip_pixel_buffer_core_test.sv */
module led_strip_pixel_buffer_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STRIP_MAX    = 256;
  localparam int unsigned RANDOM_ITEMS = 750;
  localparam int unsigned CYCLE_LIMIT  = 2_000_000;

  // Codes the block leaves unused.
  localparam logic [lspb_pkg::OPCODE_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [lspb_pkg::OPCODE_W-1:0] OP_SPARE_HI = 3'd7;
  localparam logic [lspb_pkg::ORDER_W-1:0]  ORDER_SPARE = 2'd3;

  logic                             clk = 1'b0;
  logic                             rst_n;
  logic                             cfg_we;
  logic [lspb_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [lspb_pkg::CFG_DATA_W-1:0]  cfg_data;
  logic                             in_valid;
  logic                             in_ready;
  logic [lspb_pkg::OPCODE_W-1:0]    opcode;
  logic [lspb_pkg::INDEX_W-1:0]     pixel_index;
  logic [lspb_pkg::CHAN_W-1:0]      red;
  logic [lspb_pkg::CHAN_W-1:0]      green;
  logic [lspb_pkg::CHAN_W-1:0]      blue;
  logic                             out_valid;
  logic                             out_ready;
  logic [lspb_pkg::CHAN_W-1:0]      red_out;
  logic [lspb_pkg::CHAN_W-1:0]      green_out;
  logic [lspb_pkg::CHAN_W-1:0]      blue_out;
  logic [lspb_pkg::CHAN_W-1:0]      wire_byte;
  logic                             frame_end;

  int unsigned fails;
  int unsigned pending;
  int unsigned replies;
  int unsigned items_sent = 0;
  int unsigned settings = 0;
  int unsigned cycle_count = 0;
  bit          steady = 1'b0;

  led_strip_pixel_buffer_core #(
    .MAX_PIXELS(STRIP_MAX)
  ) u_top (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .opcode_i     (opcode),
    .pixel_index_i(pixel_index),
    .red_i        (red),
    .green_i      (green),
    .blue_i       (blue),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .red_out_o    (red_out),
    .green_out_o  (green_out),
    .blue_out_o   (blue_out),
    .wire_byte_o  (wire_byte),
    .frame_end_o  (frame_end)
  );

  pixel_buffer_tracker #(
    .MAX_PIXELS(STRIP_MAX)
  ) u_tracker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .opcode_i     (opcode),
    .pixel_index_i(pixel_index),
    .red_i        (red),
    .green_i      (green),
    .blue_i       (blue),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .red_out_i    (red_out),
    .green_out_i  (green_out),
    .blue_out_i   (blue_out),
    .wire_byte_i  (wire_byte),
    .frame_end_i  (frame_end),
    .fail_count_o (fails),
    .pending_o    (pending),
    .replies_o    (replies)
  );

  always #6 clk = ~clk;

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Mostly no gap, some short ones and a rare long one; none in a steady phase.
  function automatic int unsigned idle_cycles();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Indexes mostly inside the strip, often at its edge, sometimes anywhere.
  function automatic logic [lspb_pkg::INDEX_W-1:0] pick_index(input int unsigned n);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60)
      return lspb_pkg::INDEX_W'((n == 0) ? $urandom_range(0, 3) : $urandom_range(0, n - 1));
    if (roll < 80)
      return lspb_pkg::INDEX_W'((n == 0) ? $urandom_range(0, 2) : n - 1 + $urandom_range(0, 2));
    return lspb_pkg::INDEX_W'($urandom_range(0, 1023));
  endfunction

  // One input transfer; returns at the edge that accepted it.
  task automatic send_op(input logic [lspb_pkg::OPCODE_W-1:0] op,
                         input logic [lspb_pkg::INDEX_W-1:0] idx,
                         input logic [lspb_pkg::CHAN_W-1:0] r,
                         input logic [lspb_pkg::CHAN_W-1:0] g,
                         input logic [lspb_pkg::CHAN_W-1:0] b);
    int unsigned gap;
    gap = idle_cycles();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    pixel_index <= idx;
    red <= r;
    green <= g;
    blue <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // Registers change only once every result is back and the block has settled.
  task automatic write_reg(input logic [lspb_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [lspb_pkg::CFG_DATA_W-1:0] data);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings++;
  endtask

  task automatic random_item(input int unsigned n);
    int unsigned                   roll;
    logic [lspb_pkg::OPCODE_W-1:0] op;
    roll = $urandom_range(0, 99);
    if (roll < 22) op = lspb_pkg::OP_SET;
    else if (roll < 44) op = lspb_pkg::OP_GET;
    else if (roll < 52) op = lspb_pkg::OP_PUSH_FRONT;
    else if (roll < 60) op = lspb_pkg::OP_PUSH_BACK;
    else if (roll < 65) op = lspb_pkg::OP_FILL;
    else if (roll < 95) op = lspb_pkg::OP_NEXT_BYTE;
    else if (roll < 97) op = OP_SPARE_LO;
    else op = OP_SPARE_HI;
    send_op(op, pick_index(n), lspb_pkg::CHAN_W'($urandom), lspb_pkg::CHAN_W'($urandom),
            lspb_pkg::CHAN_W'($urandom));
  endtask

  // Both register settings, then a run of operations, with whole frames read out
  // now and then on short strips.
  task automatic random_phase();
    int unsigned                      roll;
    int unsigned                      count;
    int unsigned                      done_items;
    int unsigned                      n;
    int unsigned                      burst;
    logic [lspb_pkg::STRIP_LEN_W-1:0] len;
    logic [lspb_pkg::CFG_DATA_W-1:0]  order_word;
    roll = $urandom_range(0, 99);
    if (roll < 8) len = '0;
    else if (roll < 18) len = 9'd1;
    else if (roll < 60) len = lspb_pkg::STRIP_LEN_W'($urandom_range(2, 8));
    else if (roll < 80) len = lspb_pkg::STRIP_LEN_W'($urandom_range(9, 32));
    else if (roll < 87) len = 9'd255;
    else if (roll < 94) len = 9'd256;
    else len = lspb_pkg::STRIP_LEN_W'($urandom_range(257, 511));
    write_reg(lspb_pkg::REG_STRIP_LENGTH, lspb_pkg::CFG_DATA_W'(len));
    order_word = lspb_pkg::CFG_DATA_W'($urandom);
    if ($urandom_range(0, 1) == 0) order_word[lspb_pkg::CFG_DATA_W-1:lspb_pkg::ORDER_W] = '0;
    write_reg(lspb_pkg::REG_COLOR_ORDER, order_word);
    steady = ($urandom_range(0, 3) == 0);
    n = (len > STRIP_MAX) ? STRIP_MAX : len;
    count = $urandom_range(40, 80);
    done_items = 0;
    while (done_items < count) begin
      if (n <= 32 && $urandom_range(0, 99) < 8) begin
        burst = 3 * n + $urandom_range(1, 3);
        repeat (burst)
          send_op(lspb_pkg::OP_NEXT_BYTE, pick_index(n), lspb_pkg::CHAN_W'($urandom),
                  lspb_pkg::CHAN_W'($urandom), lspb_pkg::CHAN_W'($urandom));
        done_items += burst;
      end else begin
        random_item(n);
        done_items++;
      end
    end
  endtask

  // Short directed run over the extremes and the corner cases.
  task automatic directed_run();
    // Full strip, RGB: range edges, shifts and unused codes.
    send_op(lspb_pkg::OP_SET, 10'd0, 8'hff, 8'h00, 8'h80);
    send_op(lspb_pkg::OP_SET, 10'd255, 8'h01, 8'h7f, 8'hfe);
    send_op(lspb_pkg::OP_SET, 10'd256, 8'haa, 8'haa, 8'haa);
    send_op(lspb_pkg::OP_GET, 10'd0, 8'h00, 8'h00, 8'h00);
    send_op(lspb_pkg::OP_GET, 10'd255, 8'hff, 8'hff, 8'hff);
    send_op(lspb_pkg::OP_GET, 10'd256, 8'h00, 8'h00, 8'h00);
    send_op(lspb_pkg::OP_GET, 10'd1023, 8'h00, 8'h00, 8'h00);
    send_op(lspb_pkg::OP_NEXT_BYTE, 10'd0, 8'h00, 8'h00, 8'h00);
    send_op(lspb_pkg::OP_NEXT_BYTE, 10'd1023, 8'hff, 8'hff, 8'hff);
    send_op(lspb_pkg::OP_PUSH_FRONT, 10'd0, 8'h12, 8'h34, 8'h56);
    send_op(lspb_pkg::OP_PUSH_BACK, 10'd0, 8'h9a, 8'hbc, 8'hde);
    send_op(OP_SPARE_LO, 10'h3ff, 8'hff, 8'hff, 8'hff);
    send_op(OP_SPARE_HI, 10'h155, 8'h55, 8'haa, 8'h55);
    // Four pixels in GRB, part of a frame read out.
    write_reg(lspb_pkg::REG_STRIP_LENGTH, lspb_pkg::CFG_DATA_W'(4));
    write_reg(lspb_pkg::REG_COLOR_ORDER, lspb_pkg::CFG_DATA_W'(lspb_pkg::ORDER_GRB));
    send_op(lspb_pkg::OP_FILL, 10'd0, 8'hc0, 8'hff, 8'h01);
    repeat (5) send_op(lspb_pkg::OP_NEXT_BYTE, 10'd0, 8'h00, 8'h00, 8'h00);
    // One pixel in BGR: the cursor is past the shorter frame and the old bytes decode anew.
    write_reg(lspb_pkg::REG_STRIP_LENGTH, lspb_pkg::CFG_DATA_W'(1));
    write_reg(lspb_pkg::REG_COLOR_ORDER, lspb_pkg::CFG_DATA_W'(lspb_pkg::ORDER_BGR));
    send_op(lspb_pkg::OP_GET, 10'd0, 8'h00, 8'h00, 8'h00);
    repeat (3) send_op(lspb_pkg::OP_NEXT_BYTE, 10'd0, 8'h00, 8'h00, 8'h00);
    send_op(lspb_pkg::OP_PUSH_FRONT, 10'd0, 8'h11, 8'h22, 8'h33);
    send_op(lspb_pkg::OP_PUSH_BACK, 10'd0, 8'h44, 8'h55, 8'h66);
    // Empty strip with the unused order code.
    write_reg(lspb_pkg::REG_STRIP_LENGTH, lspb_pkg::CFG_DATA_W'(0));
    write_reg(lspb_pkg::REG_COLOR_ORDER, lspb_pkg::CFG_DATA_W'(ORDER_SPARE));
    send_op(lspb_pkg::OP_PUSH_FRONT, 10'd0, 8'hff, 8'hff, 8'hff);
    send_op(lspb_pkg::OP_FILL, 10'd0, 8'hff, 8'hff, 8'hff);
    send_op(lspb_pkg::OP_NEXT_BYTE, 10'd0, 8'h00, 8'h00, 8'h00);
    send_op(lspb_pkg::OP_GET, 10'd0, 8'h00, 8'h00, 8'h00);
  endtask

  // Result side: bursts of ready broken by random stalls.
  initial begin
    int unsigned run;
    int unsigned hold;
    out_ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      run = $urandom_range(1, 24);
      repeat (run) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
      hold = idle_cycles();
      repeat (hold) begin
        out_ready <= 1'b0;
        @(posedge clk);
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    int unsigned directed_items;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    opcode = '0;
    pixel_index = '0;
    red = '0;
    green = '0;
    blue = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_run();
    directed_items = items_sent;
    while (items_sent < directed_items + RANDOM_ITEMS) random_phase();

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d operations (%0d directed) over %0d register writes",
             items_sent, directed_items, settings);
    $display("checked %0d results, %0d failures, %0d still outstanding",
             replies, fails, pending);
    if (fails == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
